[src/fat_directory_file_search_top_defines.svh]
// Assertion macros shared by the directory search modules.
`ifndef FAT_DIRECTORY_FILE_SEARCH_TOP_DEFINES_SVH
`define FAT_DIRECTORY_FILE_SEARCH_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define DFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DFS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/dfs_pkg.sv]
// Types and constants of the FAT directory file search.
package dfs_pkg;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_END       = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    localparam logic [7:0] DELETED_MARK   = 8'hE5;
    localparam logic [7:0] END_MARK       = 8'h00;
    localparam int         NAME_LEN       = 11;
    localparam logic [4:0] OFF_NAME_END   = 5'd11;
    localparam logic [4:0] OFF_CL_HI_B0   = 5'd20;
    localparam logic [4:0] OFF_CL_HI_B1   = 5'd21;
    localparam logic [4:0] OFF_CL_LO_B0   = 5'd26;
    localparam logic [4:0] OFF_CL_LO_B1   = 5'd27;
    localparam logic [4:0] OFF_SIZE_B0    = 5'd28;
    localparam logic [4:0] OFF_ENTRY_LAST = 5'd31;

    localparam logic [1:0] CFG_WANT_MAIN  = 2'd0;
    localparam logic [1:0] CFG_WANT_EXT   = 2'd1;
    localparam logic [1:0] CFG_FAT32_MODE = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] dir_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] want_main;
        logic [23:0] want_ext;
        logic        fat32_mode;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [31:0] first_cluster;
        logic [31:0] size_bytes;
    } t_result;

endpackage

[src/fat_directory_file_search_top.sv]
// Top level of the FAT directory file search.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser kind, tdata directory byte, tlast end of area
//   m_axis    out        tuser status, tdata first cluster and size in bytes
//   i_cfg_*   in         register writes: name main, name extension, FAT32 mode
//
// A beat enters the input register, is decided combinationally by the entry scan
// and lands in the result register: one byte per cycle while m_axis is not held.
// A result beat is registered as the byte causing it leaves the input register.
// Reset is synchronous and active low; it clears search, config and valid flags.
// A stalled result stops the input register, and s_axis_tready falls only then.
`include "fat_directory_file_search_top_defines.svh"

module fat_directory_file_search_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] dir_byte
    input  logic        s_axis_tuser,   // [0] kind
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] first_cluster, [63:32] size_bytes
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import dfs_pkg::*;

    t_cfg     r_cfg;
    t_in_item in_item;
    t_in_item stage_item;
    logic     stage_valid;
    logic     go;
    logic     res_valid;
    t_result  res;
    t_result  out_res;

    assign in_item = '{kind: s_axis_tuser, dir_byte: s_axis_tdata, last: s_axis_tlast};
    assign go      = stage_valid && (!m_axis_tvalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{want_main: 64'h0, want_ext: 24'h0, fat32_mode: 1'b0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WANT_MAIN:  r_cfg.want_main  <= i_cfg_data;
                CFG_WANT_EXT:   r_cfg.want_ext   <= i_cfg_data[23:0];
                CFG_FAT32_MODE: r_cfg.fat32_mode <= i_cfg_data[0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    dfs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_go    (go),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    dfs_entry_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (stage_item),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dfs_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tuser = out_res.status;
    assign m_axis_tdata = {out_res.size_bytes, out_res.first_cluster};

    `DFS_ASSERT_SAME(a_zero_unless_found, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser != ST_FOUND, m_axis_tdata == 64'h0)
    `DFS_ASSERT_SAME(a_load_only_when_free, i_clk, i_rst_n,
        res_valid, !m_axis_tvalid || m_axis_tready)

endmodule

[src/dfs_in_reg.sv]
// Input register stage holding one accepted stream beat.
module dfs_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dfs_pkg::t_in_item i_item,
    input  logic              i_go,
    output logic              o_valid,
    output dfs_pkg::t_in_item o_item
);
    import dfs_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_go;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_go) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[src/dfs_entry_scan.sv]
// Directory entry state and per-byte search decision.
`include "fat_directory_file_search_top_defines.svh"

module dfs_entry_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  dfs_pkg::t_in_item i_item,
    input  dfs_pkg::t_cfg     i_cfg,
    output logic              o_res_valid,
    output dfs_pkg::t_result  o_res
);
    import dfs_pkg::*;

    logic [4:0]  r_off,  n_off;
    logic        r_match, n_match;
    logic        r_skip, n_skip;
    logic [15:0] r_hi,   n_hi;
    logic [15:0] r_lo,   n_lo;
    logic [31:0] r_size, n_size;
    logic        r_done, n_done;

    logic [87:0] want_all;
    logic [7:0]  want_tab [16];
    logic        hit;
    t_result     res;

    assign want_all = {i_cfg.want_ext, i_cfg.want_main};

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            want_tab[k] = 8'h00;
        end
        for (int k = 0; k < NAME_LEN; k++) begin
            want_tab[k] = want_all[8*k +: 8];
        end
    end

    always_comb begin
        n_off   = r_off;
        n_match = r_match;
        n_skip  = r_skip;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_size  = r_size;
        n_done  = r_done;
        hit     = 1'b0;
        res     = '{status: ST_EXHAUSTED, first_cluster: 32'h0, size_bytes: 32'h0};
        if (i_go) begin
            if (i_item.kind) begin
                n_off   = 5'd0;
                n_match = 1'b1;
                n_skip  = 1'b0;
                n_hi    = 16'h0;
                n_lo    = 16'h0;
                n_size  = 32'h0;
                n_done  = 1'b0;
            end else if (!r_done) begin
                if (r_off == 5'd0 && i_item.dir_byte == END_MARK) begin
                    n_done     = 1'b1;
                    hit        = 1'b1;
                    res.status = ST_END;
                end else begin
                    if (r_off == 5'd0 && i_item.dir_byte == DELETED_MARK) begin
                        n_skip = 1'b1;
                    end
                    if (r_off < OFF_NAME_END && i_item.dir_byte != want_tab[r_off[3:0]]) begin
                        n_match = 1'b0;
                    end
                    priority if (r_off == OFF_CL_HI_B0) begin
                        n_hi[7:0] = i_item.dir_byte;
                    end else if (r_off == OFF_CL_HI_B1) begin
                        n_hi[15:8] = i_item.dir_byte;
                    end else if (r_off == OFF_CL_LO_B0) begin
                        n_lo[7:0] = i_item.dir_byte;
                    end else if (r_off == OFF_CL_LO_B1) begin
                        n_lo[15:8] = i_item.dir_byte;
                    end else if (r_off >= OFF_SIZE_B0) begin
                        n_size[{r_off[1:0], 3'b000} +: 8] = i_item.dir_byte;
                    end else begin
                        n_size = r_size;
                    end
                    if (r_off == OFF_ENTRY_LAST) begin
                        if (!n_skip && n_match) begin
                            n_done            = 1'b1;
                            hit               = 1'b1;
                            res.status        = ST_FOUND;
                            res.first_cluster = i_cfg.fat32_mode ? {n_hi, n_lo}
                                                                 : {16'h0, n_lo};
                            res.size_bytes    = n_size;
                        end else begin
                            n_off   = 5'd0;
                            n_match = 1'b1;
                            n_skip  = 1'b0;
                            n_hi    = 16'h0;
                            n_lo    = 16'h0;
                            n_size  = 32'h0;
                        end
                    end else begin
                        n_off = r_off + 5'd1;
                    end
                    if (!hit && i_item.last) begin
                        n_done     = 1'b1;
                        hit        = 1'b1;
                        res.status = ST_EXHAUSTED;
                    end
                end
            end
        end
    end

    assign o_res_valid = hit;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= 5'd0;
            r_match <= 1'b1;
            r_skip  <= 1'b0;
            r_hi    <= 16'h0;
            r_lo    <= 16'h0;
            r_size  <= 32'h0;
            r_done  <= 1'b0;
        end else begin
            r_off   <= n_off;
            r_match <= n_match;
            r_skip  <= n_skip;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
            r_size  <= n_size;
            r_done  <= n_done;
        end
    end

    `DFS_ASSERT_SAME(a_no_result_on_restart, i_clk, i_rst_n, i_go && i_item.kind, !o_res_valid)
    `DFS_ASSERT_NEXT(a_done_after_result, i_clk, i_rst_n, o_res_valid, r_done)

endmodule

[src/dfs_out_reg.sv]
// Result register that holds one beat until the sink takes it.
module dfs_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dfs_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output dfs_pkg::t_result o_res
);
    import dfs_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
